>>> rtl/assert_macros.svh
// Assertion macros used by the timer bank RTL.
// Every assertion is clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property check on the block clock.
`define TTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must never be true.
`define TTB_NEVER(lbl, cond, msg) \
  `TTB_ASSERT(lbl, !(cond), msg)

`endif

>>> rtl/ttb_pkg.sv
// Package for the tick timer bank: opcodes, result kinds, controller states,
// default sizes and the command and status structs. No dependencies.
package ttb_pkg;

  localparam int TIMER_COUNT_DEF = 8;
  localparam int TASK_COUNT_DEF  = 8;

  localparam logic [15:0] SLICE_RESET = 16'd10;

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_SLICE = 1'b1;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_SLEEP = 3'd3,
    OP_QUERY = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    KIND_EXPIRED = 3'd0,
    KIND_WOKEN   = 3'd1,
    KIND_SLICE   = 3'd2,
    KIND_DONE    = 3'd3,
    KIND_STATUS  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TIMER,
    ST_TASK,
    ST_SLICE,
    ST_DONE,
    ST_QUERY
  } state_e;

  typedef struct packed {
    logic accept;
    logic timer_step;
    logic task_step;
    logic slice_step;
    logic done_step;
    logic query_step;
  } ctrl_t;

  typedef struct packed {
    logic stall;
  } stat_t;

endpackage

>>> rtl/ttb_ctrl.sv
// Controller of the tick timer bank: sequences the timer walk, task walk,
// slice step and final result of a tick, and the status answer of a query.
// Depends on ttb_pkg.
module ttb_ctrl #(
  parameter int TIMER_COUNT = ttb_pkg::TIMER_COUNT_DEF,
  parameter int TASK_COUNT  = ttb_pkg::TASK_COUNT_DEF,
  parameter int CW          = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [2:0]      opcode_i,
  input  ttb_pkg::stat_t  stat_i,
  output logic            in_ready_o,
  output ttb_pkg::ctrl_t  ctrl_o,
  output logic [CW-1:0]   idx_o
);

  ttb_pkg::state_e state_q, state_d;
  logic [CW-1:0]   idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttb_pkg::ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ttb_pkg::ST_IDLE: begin
        idx_d = '0;
        if (in_valid_i) begin
          unique case (opcode_i)
            ttb_pkg::OP_TICK:  state_d = ttb_pkg::ST_TIMER;
            ttb_pkg::OP_QUERY: state_d = ttb_pkg::ST_QUERY;
            default:           state_d = ttb_pkg::ST_IDLE;
          endcase
        end
      end
      ttb_pkg::ST_TIMER: begin
        if (!stat_i.stall) begin
          if (idx_q == CW'(TIMER_COUNT - 1)) begin
            state_d = ttb_pkg::ST_TASK;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ttb_pkg::ST_TASK: begin
        if (!stat_i.stall) begin
          if (idx_q == CW'(TASK_COUNT - 1)) begin
            state_d = ttb_pkg::ST_SLICE;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ttb_pkg::ST_SLICE: begin
        if (!stat_i.stall) state_d = ttb_pkg::ST_DONE;
      end
      ttb_pkg::ST_DONE: begin
        if (!stat_i.stall) state_d = ttb_pkg::ST_IDLE;
      end
      ttb_pkg::ST_QUERY: begin
        if (!stat_i.stall) state_d = ttb_pkg::ST_IDLE;
      end
      default: begin
        state_d = ttb_pkg::ST_IDLE;
        idx_d   = '0;
      end
    endcase
  end

  always_comb begin
    in_ready_o        = (state_q == ttb_pkg::ST_IDLE);
    ctrl_o.accept     = in_ready_o && in_valid_i;
    ctrl_o.timer_step = (state_q == ttb_pkg::ST_TIMER);
    ctrl_o.task_step  = (state_q == ttb_pkg::ST_TASK);
    ctrl_o.slice_step = (state_q == ttb_pkg::ST_SLICE);
    ctrl_o.done_step  = (state_q == ttb_pkg::ST_DONE);
    ctrl_o.query_step = (state_q == ttb_pkg::ST_QUERY);
    idx_o             = idx_q;
  end

endmodule

>>> rtl/ttb_datapath.sv
// Datapath of the tick timer bank: timer and sleep state, tick clock, slice
// counter and the output register. Driven by ttb_ctrl; depends on ttb_pkg.
module ttb_datapath #(
  parameter int TIMER_COUNT = ttb_pkg::TIMER_COUNT_DEF,
  parameter int TASK_COUNT  = ttb_pkg::TASK_COUNT_DEF,
  parameter int CW          = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ttb_pkg::ctrl_t  ctrl_i,
  input  logic [CW-1:0]   idx_i,
  input  logic [2:0]      opcode_i,
  input  logic [2:0]      slot_i,
  input  logic [15:0]     initial_ticks_i,
  input  logic [15:0]     reload_ticks_i,
  input  logic            mode_i,
  input  logic [15:0]     slice_length_i,
  input  logic            out_ready_i,
  output ttb_pkg::stat_t  stat_o,
  output logic            out_valid_o,
  output logic [2:0]      kind_o,
  output logic [2:0]      slot_out_o,
  output logic [15:0]     remaining_o,
  output logic [7:0]      expiry_total_o,
  output logic            active_out_o,
  output logic [31:0]     tick_time_o,
  output logic            last_o
);

  localparam int TIW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int KIW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

  logic [15:0] rem_q   [TIMER_COUNT];
  logic [15:0] rel_q   [TIMER_COUNT];
  logic [7:0]  exp_q   [TIMER_COUNT];
  logic        act_q   [TIMER_COUNT];
  logic [15:0] sleep_q [TASK_COUNT];
  logic [31:0] clk_q;
  logic [15:0] slice_q;
  logic [2:0]  slot_q;

  logic            out_valid_q;
  logic [2:0]      kind_q;
  logic [2:0]      slot_out_q;
  logic [15:0]     rem_out_q;
  logic [7:0]      exp_out_q;
  logic            act_out_q;
  logic            last_q;
  logic [31:0]     time_out_q;

  logic [4:0]     idx_ext, slot_ext, qslot_ext;
  logic [TIW-1:0] ti, slot_ti;
  logic [KIW-1:0] ki, slot_ki;
  logic           slot_tmr_ok, slot_tsk_ok, qslot_ok;

  logic [15:0] t_rem, t_dec, t_rel, t_new_rem;
  logic [7:0]  t_exp_inc;
  logic        t_act, t_hit, t_new_act;
  logic [15:0] s_cnt, s_dec;
  logic        s_hit;
  logic [15:0] sl_dec;
  logic        sl_hit;

  logic        event_now, can_load, advance;
  logic [2:0]  kind_d, slot_out_d;
  logic [15:0] rem_out_d;
  logic [7:0]  exp_out_d;
  logic        act_out_d, last_d;

  always_comb begin
    idx_ext     = {{(5 - CW){1'b0}}, idx_i};
    slot_ext    = {2'b00, slot_i};
    qslot_ext   = {2'b00, slot_q};
    slot_tmr_ok = slot_ext < 5'(TIMER_COUNT);
    slot_tsk_ok = slot_ext < 5'(TASK_COUNT);
    qslot_ok    = qslot_ext < 5'(TIMER_COUNT);
    slot_ti     = slot_ext[TIW-1:0];
    slot_ki     = slot_ext[KIW-1:0];
    ti          = ctrl_i.query_step ? qslot_ext[TIW-1:0] : idx_ext[TIW-1:0];
    ki          = idx_ext[KIW-1:0];

    t_rem     = rem_q[ti];
    t_rel     = rel_q[ti];
    t_act     = act_q[ti];
    t_dec     = t_rem - 16'd1;
    t_hit     = t_act && (t_dec == 16'd0);
    t_exp_inc = exp_q[ti] + 8'd1;
    t_new_act = (t_rel != 16'd0);
    t_new_rem = t_new_act ? t_rel : t_dec;

    s_cnt = sleep_q[ki];
    s_dec = s_cnt - 16'd1;
    s_hit = (s_cnt == 16'd1);

    sl_dec = slice_q - 16'd1;
    sl_hit = mode_i && (sl_dec == 16'd0);

    event_now = (ctrl_i.timer_step && t_hit) || (ctrl_i.task_step && s_hit) ||
                (ctrl_i.slice_step && sl_hit) || ctrl_i.done_step || ctrl_i.query_step;
    can_load     = !out_valid_q || out_ready_i;
    stat_o.stall = event_now && !can_load;
    advance      = !stat_o.stall;
  end

  always_comb begin
    kind_d     = ttb_pkg::KIND_DONE;
    slot_out_d = 3'd0;
    rem_out_d  = 16'd0;
    exp_out_d  = 8'd0;
    act_out_d  = 1'b0;
    last_d     = 1'b0;
    if (ctrl_i.timer_step) begin
      kind_d     = ttb_pkg::KIND_EXPIRED;
      slot_out_d = idx_ext[2:0];
      rem_out_d  = t_new_rem;
      exp_out_d  = t_exp_inc;
      act_out_d  = t_new_act;
    end else if (ctrl_i.task_step) begin
      kind_d     = ttb_pkg::KIND_WOKEN;
      slot_out_d = idx_ext[2:0];
    end else if (ctrl_i.slice_step) begin
      kind_d = ttb_pkg::KIND_SLICE;
    end else if (ctrl_i.query_step) begin
      kind_d     = ttb_pkg::KIND_STATUS;
      slot_out_d = slot_q;
      last_d     = 1'b1;
      if (qslot_ok) begin
        rem_out_d = t_rem;
        exp_out_d = exp_q[ti];
        act_out_d = t_act;
      end
    end else begin
      last_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TIMER_COUNT; i++) begin
        rem_q[i] <= '0;
        rel_q[i] <= '0;
        exp_q[i] <= '0;
        act_q[i] <= 1'b0;
      end
    end else if (ctrl_i.accept) begin
      if (slot_tmr_ok) begin
        if (opcode_i == ttb_pkg::OP_START) begin
          rem_q[slot_ti] <= initial_ticks_i;
          rel_q[slot_ti] <= reload_ticks_i;
          exp_q[slot_ti] <= '0;
          act_q[slot_ti] <= 1'b1;
        end else if (opcode_i == ttb_pkg::OP_STOP) begin
          act_q[slot_ti] <= 1'b0;
        end
      end
    end else if (ctrl_i.timer_step && advance && t_act) begin
      if (t_hit) begin
        rem_q[ti] <= t_new_rem;
        exp_q[ti] <= t_exp_inc;
        act_q[ti] <= t_new_act;
      end else begin
        rem_q[ti] <= t_dec;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TASK_COUNT; i++) begin
        sleep_q[i] <= '0;
      end
    end else if (ctrl_i.accept) begin
      if (slot_tsk_ok && (opcode_i == ttb_pkg::OP_SLEEP)) begin
        sleep_q[slot_ki] <= initial_ticks_i;
      end
    end else if (ctrl_i.task_step && advance && (s_cnt != 16'd0)) begin
      sleep_q[ki] <= s_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_q   <= '0;
      slice_q <= ttb_pkg::SLICE_RESET;
      slot_q  <= '0;
    end else begin
      if (ctrl_i.accept) begin
        slot_q <= slot_i;
        if (opcode_i == ttb_pkg::OP_TICK) clk_q <= clk_q + 32'd1;
      end
      if (ctrl_i.slice_step && advance && mode_i) begin
        slice_q <= sl_hit ? slice_length_i : sl_dec;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (event_now && can_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (event_now && can_load) begin
      kind_q     <= kind_d;
      slot_out_q <= slot_out_d;
      rem_out_q  <= rem_out_d;
      exp_out_q  <= exp_out_d;
      act_out_q  <= act_out_d;
      last_q     <= last_d;
      time_out_q <= clk_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign slot_out_o     = slot_out_q;
  assign remaining_o    = rem_out_q;
  assign expiry_total_o = exp_out_q;
  assign active_out_o   = act_out_q;
  assign tick_time_o    = time_out_q;
  assign last_o         = last_q;

endmodule

>>> rtl/tick_timer_bank_unit.sv
// Top level of the tick timer bank: configuration registers on an APB-style
// port, the controller and the datapath. Depends on ttb_pkg, ttb_ctrl,
// ttb_datapath and assert_macros.svh.
//
// Channel   Direction  Handshake                 Content
// s_axis    in         tvalid/tready             one command per beat
// m_axis    out        tvalid/tready, tlast      one result per beat
// apb       in         psel/penable, pready = 1  two configuration registers
//
// A tick walks every timer and then every task, one per step, then takes the
// slice step and the final result; a query answers from its own status step.
// Start, stop and sleep apply at once; input waits until a tick or query ends.
// Every walk step that produces a result waits while the output register is
// still full and the sink is not ready, so a stalled sink stretches the tick.
// Reset clears all timer, sleep and clock state at once; no clearing pass.
`include "assert_macros.svh"

module tick_timer_bank_unit #(
  parameter int TIMER_COUNT = ttb_pkg::TIMER_COUNT_DEF,
  parameter int TASK_COUNT  = ttb_pkg::TASK_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // slot[2:0], initial_ticks[18:3], reload_ticks[34:19], zero padding
  input  logic [39:0] s_axis_tdata,
  // opcode[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // slot_out[2:0], remaining[18:3], expiry_total[26:19], active_out[27],
  // tick_time[59:28], zero padding
  output logic [63:0] m_axis_tdata,
  // kind[2:0]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int MAXC = (TIMER_COUNT > TASK_COUNT) ? TIMER_COUNT : TASK_COUNT;
  localparam int CW   = (MAXC > 1) ? $clog2(MAXC) : 1;

  logic        mode_q;
  logic [15:0] slice_len_q;

  ttb_pkg::ctrl_t ctrl;
  ttb_pkg::stat_t stat;
  logic [CW-1:0]  idx;

  logic [2:0]  slot_out;
  logic [15:0] remaining;
  logic [7:0]  expiry_total;
  logic        active_out;
  logic [31:0] tick_time;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      slice_len_q <= ttb_pkg::SLICE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        ttb_pkg::REG_MODE:  mode_q      <= pwdata[0];
        ttb_pkg::REG_SLICE: slice_len_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ttb_pkg::REG_MODE:  prdata = {31'd0, mode_q};
      ttb_pkg::REG_SLICE: prdata = {16'd0, slice_len_q};
      default:            prdata = 32'd0;
    endcase
  end

  ttb_ctrl #(
    .TIMER_COUNT (TIMER_COUNT),
    .TASK_COUNT  (TASK_COUNT),
    .CW          (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .opcode_i   (s_axis_tuser),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (ctrl),
    .idx_o      (idx)
  );

  ttb_datapath #(
    .TIMER_COUNT (TIMER_COUNT),
    .TASK_COUNT  (TASK_COUNT),
    .CW          (CW)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .idx_i           (idx),
    .opcode_i        (s_axis_tuser),
    .slot_i          (s_axis_tdata[2:0]),
    .initial_ticks_i (s_axis_tdata[18:3]),
    .reload_ticks_i  (s_axis_tdata[34:19]),
    .mode_i          (mode_q),
    .slice_length_i  (slice_len_q),
    .out_ready_i     (m_axis_tready),
    .stat_o          (stat),
    .out_valid_o     (m_axis_tvalid),
    .kind_o          (m_axis_tuser),
    .slot_out_o      (slot_out),
    .remaining_o     (remaining),
    .expiry_total_o  (expiry_total),
    .active_out_o    (active_out),
    .tick_time_o     (tick_time),
    .last_o          (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, tick_time, active_out, expiry_total, remaining, slot_out};

  `TTB_ASSERT(a_tick_busy, (s_axis_tvalid && s_axis_tready && (s_axis_tuser == ttb_pkg::OP_TICK)) |=> !s_axis_tready, "Input accepted again straight after a tick.")
  `TTB_ASSERT(a_one_step, $onehot0({ctrl.accept, ctrl.timer_step, ctrl.task_step, ctrl.slice_step, ctrl.done_step, ctrl.query_step}), "More than one controller command at once.")
  `TTB_NEVER(a_stall_empty, stat.stall && !m_axis_tvalid, "Stall raised with an empty output register.")

endmodule

>>> tb/tick_timer_bank_unit_test.sv
// Self-checking testbench for tick_timer_bank_unit: drives commands on the input stream and the
// configuration port, predicts each timer, wake, slice, done and status beat and checks them.
// Depends on ttb_pkg and the tick_timer_bank_unit RTL only.
`timescale 1ns / 100ps

module tick_timer_bank_unit_test;

  localparam int TIMERS = ttb_pkg::TIMER_COUNT_DEF;
  localparam int TASKS  = ttb_pkg::TASK_COUNT_DEF;
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_MID   = 3'd6;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 16;
  localparam int SETTLE_CYCLES = 30;
  localparam int SINK_HOLD_CYCLES = 300;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  slot;
    logic [15:0] first_ticks;
    logic [15:0] reload_ticks;
  } cmd_t;

  typedef struct packed {
    ttb_pkg::kind_e kind;
    logic [2:0]     slot;
    logic [15:0]    remaining;
    logic [7:0]     expiries;
    logic           active;
    logic [31:0]    stamp;
    logic           last;
  } bank_event_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        typed;
    bank_event_t ev;
  } script_row_t;

  localparam bank_event_t NO_EVENT =
    '{ttb_pkg::KIND_DONE, 3'd0, 16'd0, 8'd0, 1'b0, 32'd0, 1'b0};

  localparam script_row_t SCRIPT [25] = '{
    '{'{ttb_pkg::OP_QUERY, 3'd0, 16'd0, 16'd0}, 1'b1,
      '{ttb_pkg::KIND_STATUS, 3'd0, 16'd0, 8'd0, 1'b0, 32'd0, 1'b1}},
    '{'{ttb_pkg::OP_TICK, 3'd0, 16'd0, 16'd0}, 1'b1,
      '{ttb_pkg::KIND_DONE, 3'd0, 16'd0, 8'd0, 1'b0, 32'd1, 1'b1}},
    '{'{ttb_pkg::OP_START, 3'd0, 16'd1, 16'd0}, 1'b0, NO_EVENT},
    '{'{ttb_pkg::OP_START, 3'd7, 16'hFFFF, 16'hFFFF}, 1'b0, NO_EVENT},
    '{'{ttb_pkg::OP_START, 3'd3, 16'd0, 16'd2}, 1'b0, NO_EVENT},
    '{'{ttb_pkg::OP_SLEEP, 3'd0, 16'd1, 16'hFFFF}, 1'b0, NO_EVENT},
    '{'{ttb_pkg::OP_SLEEP, 3'd7, 16'hFFFF, 16'd0}, 1'b0, NO_EVENT},
    '{'{ttb_pkg::OP_QUERY, 3'd7, 16'd0, 16'd0}, 1'b1,
      '{ttb_pkg::KIND_STATUS, 3'd7, 16'hFFFF, 8'd0, 1'b1, 32'd1, 1'b1}},
    '{'{ttb_pkg::OP_TICK, 3'd0, 16'd0, 16'd0}, 1'b0, NO_EVENT},
    '{'{ttb_pkg::OP_QUERY, 3'd3, 16'd0, 16'd0}, 1'b1,
      '{ttb_pkg::KIND_STATUS, 3'd3, 16'hFFFF, 8'd0, 1'b1, 32'd2, 1'b1}},
    '{'{ttb_pkg::OP_STOP, 3'd7, 16'd0, 16'd0}, 1'b0, NO_EVENT},
    '{'{ttb_pkg::OP_QUERY, 3'd7, 16'd0, 16'd0}, 1'b1,
      '{ttb_pkg::KIND_STATUS, 3'd7, 16'hFFFE, 8'd0, 1'b0, 32'd2, 1'b1}},
    '{'{ttb_pkg::OP_START, 3'd1, 16'd2, 16'd1}, 1'b0, NO_EVENT},
    '{'{ttb_pkg::OP_TICK, 3'd0, 16'd0, 16'd0}, 1'b0, NO_EVENT},
    '{'{ttb_pkg::OP_TICK, 3'd0, 16'd0, 16'd0}, 1'b0, NO_EVENT},
    '{'{ttb_pkg::OP_TICK, 3'd0, 16'd0, 16'd0}, 1'b0, NO_EVENT},
    '{'{OP_SPARE_FIRST, 3'd2, 16'h5555, 16'hAAAA}, 1'b0, NO_EVENT},
    '{'{OP_SPARE_LAST, 3'd5, 16'hFFFF, 16'hFFFF}, 1'b0, NO_EVENT},
    '{'{OP_SPARE_MID, 3'd0, 16'hAAAA, 16'h5555}, 1'b0, NO_EVENT},
    '{'{ttb_pkg::OP_QUERY, 3'd1, 16'd0, 16'd0}, 1'b0, NO_EVENT},
    '{'{ttb_pkg::OP_SLEEP, 3'd2, 16'd0, 16'd0}, 1'b0, NO_EVENT},
    '{'{ttb_pkg::OP_START, 3'd2, 16'hFFFF, 16'd0}, 1'b0, NO_EVENT},
    '{'{ttb_pkg::OP_STOP, 3'd0, 16'd0, 16'd0}, 1'b0, NO_EVENT},
    '{'{ttb_pkg::OP_TICK, 3'd0, 16'd0, 16'd0}, 1'b0, NO_EVENT},
    '{'{ttb_pkg::OP_QUERY, 3'd2, 16'd0, 16'd0}, 1'b0, NO_EVENT}
  };

  localparam logic MODE_PLAN [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
  localparam logic [15:0] SLICE_PLAN [PHASES] = '{16'd1, 16'd3, 16'hFFFF, 16'd0, 16'd2};

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [15:0] tmr_left [TIMERS];
  logic [15:0] tmr_reload [TIMERS];
  logic        tmr_live [TIMERS];
  logic [7:0]  tmr_fired [TIMERS];
  logic [15:0] nap_left [TASKS];
  logic [31:0] tick_count;
  logic [15:0] slice_left;
  logic        slice_on;
  logic [15:0] slice_len;

  bank_event_t due_events [$];
  int          fault_count = 0;
  bit          sink_hold_req = 1'b0;

  tick_timer_bank_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_500_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void push_event(ttb_pkg::kind_e kind, int slot, logic [15:0] remaining,
                                     logic [7:0] expiries, logic active,
                                     logic [31:0] stamp, logic last);
    due_events.push_back('{kind, 3'(slot), remaining, expiries, active, stamp, last});
  endfunction

  function automatic void bank_reset();
    for (int i = 0; i < TIMERS; i++) begin
      tmr_left[i] = '0;
      tmr_reload[i] = '0;
      tmr_live[i] = 1'b0;
      tmr_fired[i] = '0;
    end
    for (int i = 0; i < TASKS; i++) nap_left[i] = '0;
    tick_count = '0;
    slice_on = 1'b0;
    slice_len = ttb_pkg::SLICE_RESET;
    slice_left = ttb_pkg::SLICE_RESET;
  endfunction

  function automatic void compute_events(cmd_t c);
    logic [31:0] next_count;
    next_count = tick_count + 32'd1;
    case (c.op)
      ttb_pkg::OP_TICK: begin
        for (int i = 0; i < TIMERS; i++) begin
          if (tmr_live[i]) begin
            tmr_left[i] = tmr_left[i] - 16'd1;
            if (tmr_left[i] == '0) begin
              tmr_fired[i] = tmr_fired[i] + 8'd1;
              if (tmr_reload[i] != '0) tmr_left[i] = tmr_reload[i];
              else tmr_live[i] = 1'b0;
              push_event(ttb_pkg::KIND_EXPIRED, i, tmr_left[i], tmr_fired[i], tmr_live[i],
                         next_count, 1'b0);
            end
          end
        end
        tick_count = next_count;
        for (int i = 0; i < TASKS; i++) begin
          if (nap_left[i] != '0) begin
            nap_left[i] = nap_left[i] - 16'd1;
            if (nap_left[i] == '0) begin
              push_event(ttb_pkg::KIND_WOKEN, i, '0, '0, 1'b0, next_count, 1'b0);
            end
          end
        end
        if (slice_on) begin
          slice_left = slice_left - 16'd1;
          if (slice_left == '0) begin
            slice_left = slice_len;
            push_event(ttb_pkg::KIND_SLICE, 0, '0, '0, 1'b0, next_count, 1'b0);
          end
        end
        push_event(ttb_pkg::KIND_DONE, 0, '0, '0, 1'b0, next_count, 1'b1);
      end
      ttb_pkg::OP_START: begin
        tmr_left[c.slot] = c.first_ticks;
        tmr_reload[c.slot] = c.reload_ticks;
        tmr_fired[c.slot] = '0;
        tmr_live[c.slot] = 1'b1;
      end
      ttb_pkg::OP_STOP: tmr_live[c.slot] = 1'b0;
      ttb_pkg::OP_SLEEP: nap_left[c.slot] = c.first_ticks;
      ttb_pkg::OP_QUERY: push_event(ttb_pkg::KIND_STATUS, c.slot, tmr_left[c.slot],
                                    tmr_fired[c.slot], tmr_live[c.slot], tick_count, 1'b1);
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] pick_ticks();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($urandom_range(1, 5));
    if (r == 6) return 16'd0;
    if (r == 7) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 17) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) c.op = ttb_pkg::OP_TICK;
    else if (r < 55) c.op = ttb_pkg::OP_START;
    else if (r < 63) c.op = ttb_pkg::OP_STOP;
    else if (r < 78) c.op = ttb_pkg::OP_SLEEP;
    else if (r < 94) c.op = ttb_pkg::OP_QUERY;
    else c.op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    c.slot = 3'($urandom_range(0, 7));
    c.first_ticks = pick_ticks();
    c.reload_ticks = ($urandom_range(0, 3) == 0) ? 16'd0 : pick_ticks();
    return c;
  endfunction

  task automatic send_cmd(cmd_t c, int gap);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, c.reload_ticks, c.first_ticks, c.slot};
    s_axis_tuser <= c.op;
    do @(posedge clk_i); while (!s_axis_tready);
    compute_events(c);
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == ttb_pkg::REG_MODE) slice_on = value[0];
    else slice_len = value[15:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d, got %0d", $realtime, name, want, got);
      fault_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    bank_event_t seen;
    bank_event_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = '{ttb_pkg::kind_e'(m_axis_tuser), m_axis_tdata[2:0], m_axis_tdata[18:3],
               m_axis_tdata[26:19], m_axis_tdata[27], m_axis_tdata[59:28], m_axis_tlast};
      if (due_events.size() == 0) begin
        $display("%0t ns: unexpected beat, expected none, got kind %0d slot %0d",
                 $realtime, seen.kind, seen.slot);
        fault_count++;
      end else begin
        want = due_events.pop_front();
        check_field("kind", 32'(want.kind), 32'(seen.kind));
        check_field("slot", 32'(want.slot), 32'(seen.slot));
        check_field("remaining", 32'(want.remaining), 32'(seen.remaining));
        check_field("expiry total", 32'(want.expiries), 32'(seen.expiries));
        check_field("active", 32'(want.active), 32'(seen.active));
        check_field("tick time", want.stamp, seen.stamp);
        check_field("last", 32'(want.last), 32'(seen.last));
      end
    end
  end

  initial begin
    int run_left;
    int pause_left;
    int hold_left;
    int r;
    m_axis_tready = 1'b0;
    run_left = 0;
    pause_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        hold_left = SINK_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (pause_left > 0) begin
        pause_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left = $urandom_range(1, 40);
          r = $urandom_range(0, 9);
          if (r < 6) pause_left = $urandom_range(1, 3);
          else if (r < 9) pause_left = 0;
          else pause_left = $urandom_range(15, 40);
        end
      end
    end
  end

  initial begin
    cmd_t c;
    int   n;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    bank_reset();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < $size(SCRIPT); i++) begin
      send_cmd(SCRIPT[i].cmd, pick_gap());
      if (SCRIPT[i].typed) begin
        void'(due_events.pop_back());
        due_events.push_back(SCRIPT[i].ev);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      write_reg(ttb_pkg::REG_MODE, 32'(MODE_PLAN[phase]));
      write_reg(ttb_pkg::REG_SLICE, 32'(SLICE_PLAN[phase]));
      // The sink holds off while the commands keep coming, so the block backs up.
      if (phase == 1) sink_hold_req = 1'b1;
      n = 0;
      while (n < PHASE_ITEMS) begin
        c = random_cmd();
        send_cmd(c, (phase == 1) ? 0 : pick_gap());
        if (c.op <= ttb_pkg::OP_QUERY) begin
          n++;
          if (phase == 2 && n == PHASE_ITEMS / 2) settle();
        end
      end
    end

    settle();
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ttb_pkg.sv
rtl/ttb_ctrl.sv
rtl/ttb_datapath.sv
rtl/tick_timer_bank_unit.sv
tb/tick_timer_bank_unit_test.sv
